// ===== design/lfia_pkg.sv =====
// Shared types and codes for the lowest-free ID allocator.
package lfia_pkg;

    // Width of the ID fields on the item channels
    localparam int ID_W = 16;

    // Request codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Register byte address
    localparam logic [1:0] ADDR_FIRST_FRESH = 2'd0;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] released_id;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            reused;
        status_t         status;
    } out_item_t;

    // Operation broadcast to every cell of the freed-ID row
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_op_t;

endpackage

// ===== design/lfia_cell.sv =====
// One slot of the sorted freed-ID row: on insert keeps, shifts in or takes the new ID; on pop takes its right neighbor.
module lfia_cell
    import lfia_pkg::*;
#(
    parameter int ID_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_op_t           op,
    input  logic [ID_BITS-1:0] new_id,
    input  logic               left_occ,
    input  logic [ID_BITS-1:0] left_data,
    input  logic               right_occ,
    input  logic [ID_BITS-1:0] right_data,
    output logic               occ,
    output logic [ID_BITS-1:0] data
);

    logic               occ_reg;
    logic               occ_next;
    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;
    logic               keep;

    // Equal entries stay ahead of the new ID
    assign keep = occ_reg && (data_reg <= new_id);

    // Insert shifts the tail right by one; pop shifts everything left; idle holds
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (op.insert)
        begin
            occ_next = occ_reg | left_occ;
            if (!keep)
            begin
                if (left_occ && (left_data > new_id))
                begin
                    data_next = left_data;
                end
                else
                begin
                    data_next = new_id;
                end
            end
        end
        else if (op.pop)
        begin
            occ_next  = right_occ;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ  = occ_reg;
    assign data = data_reg;

endmodule

// ===== design/lowest_free_id_allocator_unit.sv =====
// Top level of the lowest-free ID allocator: request/result channels, register, cell row.
//
// Usage: each transfer on the request channel (in_valid/in_ready, in_item) is either an
// allocate (func 0) or a release (func 1) of released_id. Every request yields exactly one
// transfer on the result channel (out_valid/out_ready, out_item). Allocates hand out the
// smallest released ID first (duplicates are kept and handed out once per release), then
// fresh IDs from a counter; status flags a release into a full store or an exhausted counter.
// The result sits in an output register the cycle after the request transfer. Throughput is
// one request per cycle while the output register is free or being emptied, set by the row of
// FREE_DEPTH compare cells, which performs a sorted insert or head pop for each request.
// When the receiver stalls the output register holds its result and in_ready stays high only
// if the pending result is taken in the same cycle.
// The APB register first_fresh_id (address 0) reloads the fresh counter when written; write
// it only while no request is outstanding.
// Reset empties the freed store, clears the register and the fresh counter to zero, and
// leaves the result channel empty.
module lowest_free_id_allocator_unit
    import lfia_pkg::*;
#(
    parameter int FREE_DEPTH = 16,
    parameter int ID_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                in_xfer;
    logic                cfg_wr;
    logic                is_release;
    logic                full;
    logic                have_freed;
    cell_op_t            op;
    logic [ID_BITS-1:0]  rel_id;
    logic [ID_W-1:0]     rel_field;
    logic [ID_W-1:0]     head_field;
    logic [ID_W-1:0]     fresh_field;
    logic [ID_BITS:0]    cnt_load;

    logic [ID_W-1:0]     first_fresh_reg;
    logic [ID_BITS:0]    fresh_cnt_reg;
    logic [ID_BITS:0]    fresh_cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_item_reg;
    out_item_t           out_item_next;

    logic                occ_w  [FREE_DEPTH];
    logic [ID_BITS-1:0]  data_w [FREE_DEPTH];

    // Handshakes
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_FIRST_FRESH);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_FIRST_FRESH) ? {{(32-ID_W){1'b0}}, first_fresh_reg} : '0;

    // Width adaptation between the 16-bit fields and the internal ID width
    generate
        if (ID_BITS > ID_W)
        begin : g_wide
            assign rel_id      = {{(ID_BITS-ID_W){1'b0}}, in_item.released_id};
            assign rel_field   = in_item.released_id;
            assign head_field  = data_w[0][ID_W-1:0];
            assign fresh_field = fresh_cnt_reg[ID_W-1:0];
            assign cnt_load    = {{(ID_BITS+1-ID_W){1'b0}}, pwdata[ID_W-1:0]};
        end
        else if (ID_BITS == ID_W)
        begin : g_same
            assign rel_id      = in_item.released_id;
            assign rel_field   = in_item.released_id;
            assign head_field  = data_w[0];
            assign fresh_field = fresh_cnt_reg[ID_BITS-1:0];
            assign cnt_load    = {1'b0, pwdata[ID_W-1:0]};
        end
        else
        begin : g_narrow
            assign rel_id      = in_item.released_id[ID_BITS-1:0];
            assign rel_field   = {{(ID_W-ID_BITS){1'b0}}, rel_id};
            assign head_field  = {{(ID_W-ID_BITS){1'b0}}, data_w[0]};
            assign fresh_field = {{(ID_W-ID_BITS){1'b0}}, fresh_cnt_reg[ID_BITS-1:0]};
            // A value above the ID range parks the counter in the exhausted state
            assign cnt_load    = (|pwdata[ID_W-1:ID_BITS])
                                 ? {1'b1, {ID_BITS{1'b0}}}
                                 : {1'b0, pwdata[ID_BITS-1:0]};
        end
    endgenerate

    // Store status seen from the ends of the row
    assign is_release = (in_item.func == FUNC_RELEASE);
    assign full       = occ_w[FREE_DEPTH-1];
    assign have_freed = occ_w[0];

    assign op.insert = in_xfer && is_release && !full;
    assign op.pop    = in_xfer && !is_release && have_freed;

    // Row of freed-ID cells; cell 0 sees an occupied, zero-valued left neighbor
    generate
        for (genvar i = 0; i < FREE_DEPTH; i++)
        begin : g_cell
            logic               l_occ;
            logic [ID_BITS-1:0] l_data;
            logic               r_occ;
            logic [ID_BITS-1:0] r_data;

            if (i == 0)
            begin : g_first
                assign l_occ  = 1'b1;
                assign l_data = '0;
            end
            else
            begin : g_mid
                assign l_occ  = occ_w[i-1];
                assign l_data = data_w[i-1];
            end

            if (i == FREE_DEPTH-1)
            begin : g_last
                assign r_occ  = 1'b0;
                assign r_data = '0;
            end
            else
            begin : g_rest
                assign r_occ  = occ_w[i+1];
                assign r_data = data_w[i+1];
            end

            lfia_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .new_id     (rel_id),
                .left_occ   (l_occ),
                .left_data  (l_data),
                .right_occ  (r_occ),
                .right_data (r_data),
                .occ        (occ_w[i]),
                .data       (data_w[i])
            );
        end
    endgenerate

    // Result and fresh counter update
    always_comb
    begin
        fresh_cnt_next = fresh_cnt_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cfg_wr)
        begin
            fresh_cnt_next = cnt_load;
        end
        if (in_xfer)
        begin
            out_valid_next       = 1'b1;
            out_item_next.reused = 1'b0;
            out_item_next.status = STATUS_OK;
            priority if (is_release)
            begin
                out_item_next.result_id = rel_field;
                out_item_next.status    = full ? STATUS_FULL : STATUS_OK;
            end
            else if (have_freed)
            begin
                out_item_next.result_id = head_field;
                out_item_next.reused    = 1'b1;
            end
            else if (fresh_cnt_reg[ID_BITS])
            begin
                out_item_next.result_id = '0;
                out_item_next.status    = STATUS_EXHAUSTED;
            end
            else
            begin
                out_item_next.result_id = fresh_field;
                fresh_cnt_next          = fresh_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_fresh_reg <= '0;
            fresh_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                first_fresh_reg <= pwdata[ID_W-1:0];
            end
            fresh_cnt_reg <= fresh_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== tb/lfia_checker.sv =====
// Checker for the lowest-free ID allocator: watches both channels and the register port.
`timescale 1ns / 1ps

module lfia_checker
    import lfia_pkg::*;
#(
    parameter int FREE_DEPTH = 16,
    parameter int ID_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          results_pending
);

    localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << ID_BITS) - 1);

    // Shadow copy of the allocator state
    logic [ID_W-1:0]  freed_ids [FREE_DEPTH];
    int               freed_n;
    logic [ID_BITS:0] fresh_ctr;

    // Results owed by the block, oldest first
    out_item_t        grants_due [$];
    out_item_t        oldest;

    // Serve one request against the shadow state and return the result it owes
    function automatic out_item_t serve_request(in_item_t req);
        out_item_t       res;
        logic [ID_W-1:0] id;
        int              pos;
        int              i;
        id            = req.released_id & ID_MASK;
        res.result_id = id;
        res.reused    = 1'b0;
        res.status    = STATUS_OK;
        if (req.func == FUNC_RELEASE)
        begin
            if (freed_n >= FREE_DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // sorted insert, after any equal entries
                pos = 0;
                while (pos < freed_n && freed_ids[pos] <= id)
                    pos++;
                for (i = freed_n; i > pos; i--)
                    freed_ids[i] = freed_ids[i - 1];
                freed_ids[pos] = id;
                freed_n++;
            end
        end
        else if (freed_n > 0)
        begin
            // pop the smallest freed ID
            res.result_id = freed_ids[0];
            res.reused    = 1'b1;
            for (i = 1; i < freed_n; i++)
                freed_ids[i - 1] = freed_ids[i];
            freed_n--;
        end
        else if (fresh_ctr > ID_MASK)
        begin
            res.result_id = '0;
            res.status    = STATUS_EXHAUSTED;
        end
        else
        begin
            res.result_id = fresh_ctr[ID_W-1:0];
            fresh_ctr     = fresh_ctr + 1'b1;
        end
        return res;
    endfunction

    // Track register writes, check result transfers, predict request transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freed_n         = 0;
            fresh_ctr       = '0;
            grants_due.delete();
            error_count     = 0;
            results_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_FIRST_FRESH)
                fresh_ctr = {1'b0, pwdata[ID_W-1:0]};

            if (out_valid && out_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: result_id %0d",
                           out_item.result_id);
                    error_count++;
                end
                else
                begin
                    oldest = grants_due.pop_front();
                    if (out_item.result_id !== oldest.result_id)
                    begin
                        $error("result_id: expected %0d, got %0d",
                               oldest.result_id, out_item.result_id);
                        error_count++;
                    end
                    if (out_item.reused !== oldest.reused)
                    begin
                        $error("reused: expected %0d, got %0d",
                               oldest.reused, out_item.reused);
                        error_count++;
                    end
                    if (out_item.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               oldest.status, out_item.status);
                        error_count++;
                    end
                end
            end

            // result of a request never comes back in the same cycle as the request
            if (in_valid && in_ready)
                grants_due.push_back(serve_request(in_item));

            results_pending = grants_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
    import lfia_pkg::*;

    localparam int FREE_DEPTH  = 16;
    localparam int ID_BITS     = 16;
    localparam int TOTAL_ITEMS = 1700;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          results_pending;
    int          requests_sent = 0;
    int          cycle_count = 0;
    logic        calm = 1'b0;

    lowest_free_id_allocator_unit #(
        .FREE_DEPTH (FREE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lfia_checker #(
        .FREE_DEPTH (FREE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** lowest_free_id_allocator_unit: FAILED **");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long; none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // ID mix: extremes, a small crowded range for duplicates, a range near the top, and anything
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ID_W'($urandom_range(0, 15));
            5:       return ID_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return ID_W'($urandom);
        endcase
    endfunction

    // One request transfer; entered and left at a falling edge
    task automatic send_request(logic func, logic [ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= '{func: func, released_id: id};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        @(negedge clk);
    endtask

    // Register write once every owed result has come back
    task automatic write_first_fresh(logic [ID_W-1:0] value);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIRST_FRESH;
        pwdata  <= {{(32 - ID_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random stalls with stall-free stretches
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    // Request side and verdict
    initial
    begin
        int              n;
        int              kind;
        int              episode;
        logic [ID_W-1:0] reg_val;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fresh IDs from the reset value, then releases incl. extremes and a duplicate
        send_request(FUNC_ALLOC, ID_W'($urandom));
        send_request(FUNC_ALLOC, ID_W'($urandom));
        send_request(FUNC_RELEASE, 16'hFFFF);
        send_request(FUNC_RELEASE, 16'h0000);
        send_request(FUNC_RELEASE, 16'd7);
        send_request(FUNC_RELEASE, 16'd7);
        // smallest first, each duplicate handed out once
        repeat (4) send_request(FUNC_ALLOC, ID_W'($urandom));

        // Counter runs past the top; a freed ID is still served while exhausted
        write_first_fresh(16'hFFFE);
        repeat (3) send_request(FUNC_ALLOC, ID_W'($urandom));
        send_request(FUNC_RELEASE, 16'd9);
        send_request(FUNC_ALLOC, ID_W'($urandom));
        send_request(FUNC_ALLOC, 16'hFFFF);

        // Release into a full store
        write_first_fresh(16'd100);
        repeat (FREE_DEPTH + 1) send_request(FUNC_RELEASE, pick_id());
        repeat (FREE_DEPTH + 2) send_request(FUNC_ALLOC, ID_W'($urandom));

        // Random episodes
        episode = 0;
        while (requests_sent < TOTAL_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (episode < 2 || $urandom_range(0, 2) == 0)
            begin
                case (episode)
                    0:       reg_val = '1;
                    1:       reg_val = '0;
                    default:
                        case ($urandom_range(0, 2))
                            0:       reg_val = ID_W'($urandom_range(16'hFFF0, 16'hFFFF));
                            1:       reg_val = ID_W'($urandom_range(0, 64));
                            default: reg_val = ID_W'($urandom);
                        endcase
                endcase
                write_first_fresh(reg_val);
            end
            kind = $urandom_range(0, 3);
            case (kind)
                // fill the store, often past full, then drain it into fresh IDs
                0:
                begin
                    n = $urandom_range(12, 20);
                    repeat (n) send_request(FUNC_RELEASE, pick_id());
                    repeat ($urandom_range(n - 4, n + 6))
                        send_request(FUNC_ALLOC, ID_W'($urandom));
                end
                // mostly allocates, heads into exhaustion near the top
                3:
                begin
                    repeat ($urandom_range(10, 30))
                    begin
                        if ($urandom_range(0, 5) == 0)
                            send_request(FUNC_RELEASE, pick_id());
                        else
                            send_request(FUNC_ALLOC, ID_W'($urandom));
                    end
                end
                // even mix
                default:
                begin
                    repeat ($urandom_range(20, 60))
                        send_request(logic'($urandom_range(0, 1)), pick_id());
                end
            endcase
            episode++;
        end

        // Drain and decide
        calm     = 1'b0;
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("** lowest_free_id_allocator_unit: PASSED **");
        else
            $display("** lowest_free_id_allocator_unit: FAILED **");
        $finish;
    end

endmodule
